// ===== design/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// shared types and constants of the frame store with pixel scroll
// ----------------------------------------------------------------------------
package fsp_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int PIXEL_BITS_DEF = 32;

   localparam int CFG_BITS       = 9;
   localparam int COLOR_BITS     = 32;
   localparam int SHIFT_BITS     = 10;

   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 9'd256;
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 9'd256;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } fsp_reg_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_SHIFT = 2'd2,
      OP_NONE  = 2'd3
   } fsp_op_type;

   // shift request handed to the scan engine
   typedef struct packed {
      logic                         start;
      logic signed [SHIFT_BITS-1:0] dx;
      logic signed [SHIFT_BITS-1:0] dy;
   } fsp_shift_cmd_type;

endpackage

// ===== design/fsp_ram.sv =====
// ----------------------------------------------------------------------------
// fsp_ram
// simple dual port ram, one write and one registered read port,
// a read of the address written in the same cycle returns the new data
// ----------------------------------------------------------------------------
module fsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fsp_scan.sv =====
// ----------------------------------------------------------------------------
// fsp_scan
// shift engine: copies the used rows of the frame into the copy store, then
// rebuilds them row by row from the copy, or just zeroes them on a clear
// ----------------------------------------------------------------------------
module fsp_scan #(
   parameter int MAX_WIDTH  = fsp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = fsp_pkg::MAX_HEIGHT_DEF,
   parameter int PIXEL_BITS = fsp_pkg::PIXEL_BITS_DEF,
   localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int XW        = $clog2(MAX_WIDTH + 1),
   localparam int YW        = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fsp_pkg::fsp_shift_cmd_type cmd,
   input  logic [XW-1:0]             eff_width,
   input  logic [YW-1:0]             eff_height,
   output logic                      busy,
   output logic                      frame_rd_en,
   output logic [AW-1:0]             frame_rd_addr,
   input  logic [PIXEL_BITS-1:0]     frame_rd_data,
   output logic                      frame_wr_en,
   output logic [AW-1:0]             frame_wr_addr,
   output logic [PIXEL_BITS-1:0]     frame_wr_data
);

   import fsp_pkg::*;

   localparam int MW = (XW > YW) ? XW : YW;
   localparam int SW = ((MW > SHIFT_BITS) ? MW : SHIFT_BITS) + 2;
   localparam int OW = AW + SHIFT_BITS + 2;

   typedef enum logic [2:0] {
      SCAN_IDLE  = 3'b001,
      SCAN_COPY  = 3'b010,
      SCAN_BUILD = 3'b100
   } fsp_scan_state_type;

   fsp_scan_state_type state_ff, state_in;
   logic [XW-1:0]      col_ff, col_in;
   logic [YW-1:0]      row_ff, row_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [AW-1:0]      offset_ff, offset_in;
   logic signed [SHIFT_BITS-1:0] dx_ff, dx_in;
   logic signed [SHIFT_BITS-1:0] dy_ff, dy_in;
   logic               clear_ff, clear_in;
   logic               pvld_ff, pvld_in;
   logic               pcopy_ff, pcopy_in;
   logic               psrc_ff, psrc_in;
   logic [AW-1:0]      paddr_ff, paddr_in;

   logic               last_col;
   logic               last_row;
   logic signed [SW-1:0] su;
   logic signed [SW-1:0] sv;
   logic               src_ok;
   logic [OW-1:0]      offset_full;
   logic               copy_wr_en;
   logic               copy_rd_en;
   logic [AW-1:0]      copy_rd_addr;
   logic [PIXEL_BITS-1:0] copy_rd_data;

   always_comb begin
      last_col = (col_ff == XW'(MAX_WIDTH - 1));
      last_row = (row_ff == YW'(eff_height - 1'b1));
      su = SW'($signed({1'b0, col_ff})) + SW'(dx_ff);
      sv = SW'($signed({1'b0, row_ff})) + SW'(dy_ff);
      // columns beyond the window come out zero
      src_ok = !clear_ff && !su[SW-1] && !sv[SW-1]
               && (col_ff < eff_width)
               && (su < SW'($signed({1'b0, eff_width})))
               && (sv < SW'($signed({1'b0, eff_height})));
      offset_full = OW'(cmd.dy) * OW'(MAX_WIDTH) + OW'(cmd.dx);
   end

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      addr_in   = addr_ff;
      offset_in = offset_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      clear_in  = clear_ff;
      if (last_col) begin
         col_in = '0;
         row_in = row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
      end
      addr_in = addr_ff + 1'b1;
      case (state_ff)
         SCAN_IDLE: begin
            col_in  = '0;
            row_in  = '0;
            addr_in = '0;
            if (cmd.start && (eff_height != '0)) begin
               clear_in  = (cmd.dx == '0) && (cmd.dy == '0);
               state_in  = clear_in ? SCAN_BUILD : SCAN_COPY;
               dx_in     = cmd.dx;
               dy_in     = cmd.dy;
               offset_in = offset_full[AW-1:0];
            end
         end
         SCAN_COPY: begin
            if (last_col && last_row) begin
               state_in = SCAN_BUILD;
               col_in   = '0;
               row_in   = '0;
               addr_in  = '0;
            end
         end
         SCAN_BUILD: begin
            if (last_col && last_row) begin
               state_in = SCAN_IDLE;
            end
         end
         default: begin
            state_in = SCAN_IDLE;
         end
      endcase
      pvld_in  = (state_ff == SCAN_COPY) || (state_ff == SCAN_BUILD);
      pcopy_in = (state_ff == SCAN_COPY);
      psrc_in  = src_ok;
      paddr_in = addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         pvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pvld_ff  <= pvld_in;
      end
      col_ff    <= col_in;
      row_ff    <= row_in;
      addr_ff   <= addr_in;
      offset_ff <= offset_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      clear_ff  <= clear_in;
      pcopy_ff  <= pcopy_in;
      psrc_ff   <= psrc_in;
      paddr_ff  <= paddr_in;
   end

   assign copy_wr_en   = pvld_ff && pcopy_ff;
   assign copy_rd_en   = (state_ff == SCAN_BUILD) && src_ok;
   assign copy_rd_addr = addr_ff + offset_ff;

   fsp_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (DEPTH)
   ) u_copy_ram (
      .clock   (clock),
      .wr_en   (copy_wr_en),
      .wr_addr (paddr_ff),
      .wr_data (frame_rd_data),
      .rd_en   (copy_rd_en),
      .rd_addr (copy_rd_addr),
      .rd_data (copy_rd_data)
   );

   assign busy          = (state_ff != SCAN_IDLE) || pvld_ff;
   assign frame_rd_en   = (state_ff == SCAN_COPY);
   assign frame_rd_addr = addr_ff;
   assign frame_wr_en   = pvld_ff && !pcopy_ff;
   assign frame_wr_addr = paddr_ff;
   assign frame_wr_data = psrc_ff ? copy_rd_data : '0;

endmodule

// ===== design/frame_store_pixel_scroll.sv =====
// ----------------------------------------------------------------------------
// frame_store_pixel_scroll
// frame store of pixels with write, read and scroll of the whole image
// ----------------------------------------------------------------------------
// A write pixel request does not hold the request channel; a read pixel
// request holds it until the registered read port of the frame memory has
// given its data. A shift image request occupies the block while the single
// frame memory is walked once to copy every used row into the copy store and
// once more to rebuild it, one pixel a cycle; a shift of zero (a clear) skips
// the copy. Responses queue in a two-entry buffer, so requests keep flowing
// while one response waits. No memory is cleared after reset: a pixel read
// before it was written returns an unspecified value.
// ----------------------------------------------------------------------------
module frame_store_pixel_scroll #(
   parameter int MAX_WIDTH  = fsp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = fsp_pkg::MAX_HEIGHT_DEF,
   parameter int PIXEL_BITS = fsp_pkg::PIXEL_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [71:0]                    req_tdata,  // pixel_x, pixel_y, pixel_color,
                                                      // shift_x, shift_y
   input  logic [1:0]                     req_tuser,  // opcode
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [39:0]                    rsp_tdata,  // read_color, out_of_range
   // register writes
   input  logic                           csr_wr_en,
   input  logic [0:0]                     csr_index,
   input  logic [fsp_pkg::CFG_BITS-1:0]   csr_wdata
);

   import fsp_pkg::*;

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int RW    = COLOR_BITS + 1;

   logic [CFG_BITS-1:0] width_ff, width_in;
   logic [CFG_BITS-1:0] height_ff, height_in;
   logic [XW-1:0]       eff_width;
   logic [YW-1:0]       eff_height;

   fsp_op_type              op;
   logic [7:0]              pixel_x;
   logic [7:0]              pixel_y;
   logic [COLOR_BITS-1:0]   pixel_color;
   logic signed [SHIFT_BITS-1:0] shift_x;
   logic signed [SHIFT_BITS-1:0] shift_y;
   logic                    accept;
   logic                    in_window;
   logic [AW-1:0]           pixel_addr;

   fsp_shift_cmd_type       shift_cmd;
   logic                    scan_busy;
   logic                    scan_rd_en;
   logic [AW-1:0]           scan_rd_addr;
   logic                    scan_wr_en;
   logic [AW-1:0]           scan_wr_addr;
   logic [PIXEL_BITS-1:0]   scan_wr_data;

   logic                    frame_wr_en;
   logic [AW-1:0]           frame_wr_addr;
   logic [PIXEL_BITS-1:0]   frame_wr_data;
   logic                    frame_rd_en;
   logic [AW-1:0]           frame_rd_addr;
   logic [PIXEL_BITS-1:0]   frame_rd_data;

   logic                    rd_pend_ff, rd_pend_in;
   logic                    rd_oor_ff, rd_oor_in;

   logic [RW-1:0]           q_ff [2];
   logic                    q_wr_ptr_ff, q_wr_ptr_in;
   logic                    q_rd_ptr_ff, q_rd_ptr_in;
   logic [1:0]              q_count_ff, q_count_in;
   logic                    push;
   logic                    pop;
   logic [RW-1:0]           push_data;

   // register file
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (fsp_reg_type'(csr_index))
            REG_IMAGE_WIDTH:  width_in  = csr_wdata;
            REG_IMAGE_HEIGHT: height_in = csr_wdata;
            default: begin
               width_in = width_ff;
            end
         endcase
      end
      eff_width  = (32'(width_ff) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(width_ff);
      eff_height = (32'(height_ff) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(height_ff);
   end

   // request decode
   always_comb begin
      op          = fsp_op_type'(req_tuser);
      pixel_x     = req_tdata[7:0];
      pixel_y     = req_tdata[15:8];
      pixel_color = req_tdata[47:16];
      shift_x     = req_tdata[57:48];
      shift_y     = req_tdata[67:58];
      accept      = req_tvalid && req_tready;
      in_window   = (32'(pixel_x) < 32'(eff_width)) && (32'(pixel_y) < 32'(eff_height));
      pixel_addr  = AW'(32'(pixel_y) * MAX_WIDTH + 32'(pixel_x));
      shift_cmd.start = accept && (op == OP_SHIFT);
      shift_cmd.dx    = shift_x;
      shift_cmd.dy    = shift_y;
   end

   assign req_tready = !scan_busy && !rd_pend_ff && (q_count_ff != 2'd2);

   fsp_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .cmd           (shift_cmd),
      .eff_width     (eff_width),
      .eff_height    (eff_height),
      .busy          (scan_busy),
      .frame_rd_en   (scan_rd_en),
      .frame_rd_addr (scan_rd_addr),
      .frame_rd_data (frame_rd_data),
      .frame_wr_en   (scan_wr_en),
      .frame_wr_addr (scan_wr_addr),
      .frame_wr_data (scan_wr_data)
   );

   // frame memory port sharing
   always_comb begin
      if (scan_busy) begin
         frame_wr_en   = scan_wr_en;
         frame_wr_addr = scan_wr_addr;
         frame_wr_data = scan_wr_data;
         frame_rd_en   = scan_rd_en;
         frame_rd_addr = scan_rd_addr;
      end else begin
         frame_wr_en   = accept && (op == OP_WRITE) && in_window;
         frame_wr_addr = pixel_addr;
         frame_wr_data = pixel_color[PIXEL_BITS-1:0];
         frame_rd_en   = accept && (op == OP_READ) && in_window;
         frame_rd_addr = pixel_addr;
      end
   end

   fsp_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_wr_en),
      .wr_addr (frame_wr_addr),
      .wr_data (frame_wr_data),
      .rd_en   (frame_rd_en),
      .rd_addr (frame_rd_addr),
      .rd_data (frame_rd_data)
   );

   // response queue
   always_comb begin
      rd_pend_in = accept && (op == OP_READ);
      rd_oor_in  = !in_window;
      push       = 1'b0;
      push_data  = '0;
      if (rd_pend_ff) begin
         push      = 1'b1;
         push_data = rd_oor_ff ? {1'b1, COLOR_BITS'(0)} : {1'b0, COLOR_BITS'(frame_rd_data)};
      end else if (accept && (op != OP_READ)) begin
         push      = 1'b1;
         push_data = {(op == OP_WRITE) && !in_window, COLOR_BITS'(0)};
      end
      pop         = rsp_tvalid && rsp_tready;
      q_wr_ptr_in = push ? !q_wr_ptr_ff : q_wr_ptr_ff;
      q_rd_ptr_in = pop ? !q_rd_ptr_ff : q_rd_ptr_ff;
      q_count_in  = q_count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         rd_pend_ff  <= 1'b0;
         q_wr_ptr_ff <= 1'b0;
         q_rd_ptr_ff <= 1'b0;
         q_count_ff  <= 2'd0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         rd_pend_ff  <= rd_pend_in;
         q_wr_ptr_ff <= q_wr_ptr_in;
         q_rd_ptr_ff <= q_rd_ptr_in;
         q_count_ff  <= q_count_in;
      end
      rd_oor_ff <= rd_oor_in;
      if (push) begin
         q_ff[q_wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_tvalid = (q_count_ff != 2'd0);
   assign rsp_tdata  = {7'd0, q_ff[q_rd_ptr_ff]};

endmodule

// ===== tb/frame_store_pixel_scroll_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_store_pixel_scroll_test
// self-checking bench for the frame store with pixel scroll
// ----------------------------------------------------------------------------
// The frame is cleared once after reset so that every pixel is defined. A
// short directed run covers the corner pixels, the idle opcode, a full-frame
// scroll and a one-pixel window. Random phases then change the window size
// (empty and saturating sizes included) and mix writes, reads of recently
// written pixels, scrolls and clears. A scoreboard keeps its own image of the
// frame and checks every response in order. Both sides of the stream idle
// in short random bursts, except in the final phase.
// ----------------------------------------------------------------------------
module frame_store_pixel_scroll_test;
   import fsp_pkg::*;

   localparam int MAX_W       = MAX_WIDTH_DEF;
   localparam int MAX_H       = MAX_HEIGHT_DEF;
   localparam int FRAME_WORDS = MAX_W * MAX_H;

   typedef struct packed {
      logic [COLOR_BITS-1:0] color;
      logic                  oor;
   } pixel_rsp_type;

   class scroll_scoreboard_type;
      bit [COLOR_BITS-1:0] frame_img [FRAME_WORDS];
      bit [COLOR_BITS-1:0] scroll_copy [FRAME_WORDS];
      bit [CFG_BITS-1:0]   width_reg;
      bit [CFG_BITS-1:0]   height_reg;
      pixel_rsp_type       awaited [$];
      int                  errors;
      int                  checked;
      int                  oor_count;

      function new();
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
      endfunction

      function void write_register(fsp_reg_type idx, bit [CFG_BITS-1:0] val);
         if (idx == REG_IMAGE_WIDTH)
            width_reg = val;
         else
            height_reg = val;
      endfunction

      function int eff_w();
         return (width_reg > MAX_W) ? MAX_W : int'(width_reg);
      endfunction

      function int eff_h();
         return (height_reg > MAX_H) ? MAX_H : int'(height_reg);
      endfunction

      function void scroll_image(int dx, int dy);
         int ew;
         int eh;
         int span;
         int sv;
         int su;
         ew   = eff_w();
         eh   = eff_h();
         span = eh * MAX_W;
         if (dx == 0 && dy == 0) begin
            for (int i = 0; i < span; i++)
               frame_img[i] = '0;
            return;
         end
         for (int i = 0; i < span; i++) begin
            scroll_copy[i] = frame_img[i];
            frame_img[i]   = '0;
         end
         for (int v = 0; v < eh; v++) begin
            sv = v + dy;
            if (sv < 0 || sv >= eh)
               continue;
            for (int u = 0; u < ew; u++) begin
               su = u + dx;
               if (su < 0 || su >= ew)
                  continue;
               frame_img[v * MAX_W + u] = scroll_copy[sv * MAX_W + su];
            end
         end
      endfunction

      function void apply_request(fsp_op_type op, bit [7:0] x, bit [7:0] y,
                                  bit [COLOR_BITS-1:0] color,
                                  logic signed [SHIFT_BITS-1:0] dx,
                                  logic signed [SHIFT_BITS-1:0] dy);
         pixel_rsp_type res;
         int            idx;
         res = '0;
         idx = int'(y) * MAX_W + int'(x);
         if (op == OP_WRITE || op == OP_READ) begin
            if (int'(x) >= eff_w() || int'(y) >= eff_h())
               res.oor = 1'b1;
            else if (op == OP_WRITE)
               frame_img[idx] = color;
            else
               res.color = frame_img[idx];
         end else if (op == OP_SHIFT) begin
            scroll_image(int'(dx), int'(dy));
         end
         awaited.push_back(res);
      endfunction

      function void check_response(logic [COLOR_BITS-1:0] color, logic oor);
         pixel_rsp_type want;
         checked++;
         if (oor === 1'b1)
            oor_count++;
         if (awaited.size() == 0) begin
            $error("response with none outstanding: read_color %h out_of_range %b",
                   color, oor);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (color !== want.color) begin
            $error("read_color mismatch: expected %h, actual %h", want.color, color);
            errors++;
         end
         if (oor !== want.oor) begin
            $error("out_of_range mismatch: expected %b, actual %b", want.oor, oor);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [71:0]           req_tdata = '0;  // pixel_x, pixel_y, pixel_color, shift_x, shift_y
   logic [1:0]            req_tuser = OP_NONE;  // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;  // read_color, out_of_range
   logic                  csr_wr_en = 1'b0;
   logic [0:0]            csr_index = REG_IMAGE_WIDTH;
   logic [CFG_BITS-1:0]   csr_wdata = '0;

   scroll_scoreboard_type sb;
   int  cycle_count = 0;
   int  shift_done_at = 0;
   int  stall_left = 0;
   int  stall_pct = 20;
   int  gap_pct = 20;
   bit  calm = 1'b0;
   int  n_write = 0;
   int  n_read = 0;
   int  n_shift = 0;
   int  n_clear = 0;
   int  n_none = 0;
   logic [15:0] recent_px [$];

   frame_store_pixel_scroll i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // response back-pressure in short bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata[31:0], rsp_tdata[32]);
   end

   task automatic issue_request(fsp_op_type op, logic [7:0] x, logic [7:0] y,
                                logic [31:0] color,
                                logic signed [SHIFT_BITS-1:0] dx,
                                logic signed [SHIFT_BITS-1:0] dy);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < gap_pct)
         gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, dy, dx, color, y, x};
      do @(posedge clock); while (!req_tready);
      sb.apply_request(op, x, y, color, dx, dy);
      case (op)
         OP_WRITE: begin
            n_write++;
            if (int'(x) < sb.eff_w() && int'(y) < sb.eff_h()) begin
               recent_px.push_back({y, x});
               if (recent_px.size() > 16)
                  void'(recent_px.pop_front());
            end
         end
         OP_READ: n_read++;
         OP_SHIFT: begin
            n_shift++;
            if (dx == 0 && dy == 0)
               n_clear++;
            shift_done_at = cycle_count + 2 * MAX_W * sb.eff_h() + 8;
         end
         default: n_none++;
      endcase
   endtask

   // wait for all responses and for any scroll still walking the frame
   task automatic settle();
      int wait_cycles;
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      wait_cycles = 8;
      if (shift_done_at > cycle_count)
         wait_cycles += shift_done_at - cycle_count;
      repeat (wait_cycles) @(posedge clock);
   endtask

   task automatic set_window(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
      csr_wr_en <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= REG_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_register(REG_IMAGE_WIDTH, w);
      sb.write_register(REG_IMAGE_HEIGHT, h);
   endtask

   function automatic logic signed [SHIFT_BITS-1:0] pick_offset(int span);
      int val;
      case ($urandom_range(0, 3))
         0: val = int'($urandom_range(0, 6)) - 3;
         1: val = int'($urandom_range(0, 2 * span)) - span;
         2: val = int'($urandom_range(0, 512)) - 256;
         default: begin
            case ($urandom_range(0, 3))
               0: val = -256;
               1: val = 256;
               2: val = span;
               default: val = -span;
            endcase
         end
      endcase
      return val[SHIFT_BITS-1:0];
   endfunction

   function automatic logic [7:0] pick_coord(int span);
      if (span > 0 && $urandom_range(0, 99) < 85)
         return 8'($urandom_range(0, span - 1));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [31:0] pick_color();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_directed();
      issue_request(OP_SHIFT, 8'd0, 8'd0, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_WRITE, 8'd0, 8'd0, 32'hFFFF_FFFF, 10'sd0, 10'sd0);
      issue_request(OP_WRITE, 8'd255, 8'd255, 32'hA5A5_A5A5, 10'sd0, 10'sd0);
      issue_request(OP_WRITE, 8'd255, 8'd0, 32'h5A5A_5A5A, 10'sd0, 10'sd0);
      issue_request(OP_WRITE, 8'd0, 8'd255, 32'h0000_0001, 10'sd0, 10'sd0);
      issue_request(OP_READ, 8'd0, 8'd0, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_READ, 8'd255, 8'd255, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_READ, 8'd255, 8'd0, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_READ, 8'd0, 8'd255, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_NONE, 8'd255, 8'd255, 32'hFFFF_FFFF, -10'sd1, -10'sd1);
      // full-frame scroll, one left and one down
      issue_request(OP_SHIFT, 8'd0, 8'd0, 32'h0, 10'sd1, -10'sd1);
      issue_request(OP_READ, 8'd254, 8'd1, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_READ, 8'd0, 8'd0, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_READ, 8'd255, 8'd255, 32'h0, 10'sd0, 10'sd0);
      settle();
      set_window(9'd1, 9'd1);
      issue_request(OP_WRITE, 8'd0, 8'd0, 32'h1234_5678, 10'sd0, 10'sd0);
      issue_request(OP_WRITE, 8'd1, 8'd0, 32'hDEAD_BEEF, 10'sd0, 10'sd0);
      issue_request(OP_WRITE, 8'd0, 8'd1, 32'hDEAD_BEEF, 10'sd0, 10'sd0);
      issue_request(OP_READ, 8'd0, 8'd0, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_READ, 8'd255, 8'd255, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_SHIFT, 8'd0, 8'd0, 32'h0, 10'sd1, 10'sd0);
      issue_request(OP_READ, 8'd0, 8'd0, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_WRITE, 8'd0, 8'd0, 32'h8000_0001, 10'sd0, 10'sd0);
      issue_request(OP_SHIFT, 8'd0, 8'd0, 32'h0, -10'sd256, 10'sd256);
      issue_request(OP_READ, 8'd0, 8'd0, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_SHIFT, 8'd0, 8'd0, 32'h0, 10'sd0, 10'sd0);
      issue_request(OP_READ, 8'd0, 8'd0, 32'h0, 10'sd0, 10'sd0);
   endtask

   task automatic run_phase(int w, int h, int n_items, int shift_pct, bit last);
      int         roll;
      fsp_op_type op;
      logic [7:0] x;
      logic [7:0] y;
      logic [15:0] px;
      settle();
      set_window(w[CFG_BITS-1:0], h[CFG_BITS-1:0]);
      calm = last;
      case ($urandom_range(0, 2))
         0: gap_pct = 0;
         1: gap_pct = 15;
         default: gap_pct = 40;
      endcase
      case ($urandom_range(0, 2))
         0: stall_pct = 0;
         1: stall_pct = 15;
         default: stall_pct = 40;
      endcase
      for (int i = 0; i < n_items; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3)
            op = OP_NONE;
         else if (roll < 3 + shift_pct)
            op = OP_SHIFT;
         else if (roll < 58)
            op = OP_WRITE;
         else
            op = OP_READ;
         x = pick_coord(sb.eff_w());
         y = pick_coord(sb.eff_h());
         if (op == OP_READ && recent_px.size() > 0 && $urandom_range(0, 1) == 1) begin
            px = recent_px[$urandom_range(0, recent_px.size() - 1)];
            {y, x} = px;
         end
         issue_request(op, x, y, pick_color(),
                       pick_offset(sb.eff_w()), pick_offset(sb.eff_h()));
      end
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_phase(16, 4, 300, 6, 1'b0);
      run_phase(256, 1, 300, 6, 1'b0);
      run_phase(1, 8, 200, 5, 1'b0);
      run_phase(37, 21, 300, 2, 1'b0);
      run_phase(0, 3, 100, 5, 1'b0);
      run_phase(511, 2, 300, 5, 1'b0);
      run_phase(200, 0, 100, 5, 1'b0);
      run_phase(256, 511, 300, 0, 1'b1);
      settle();
      $display("requests: %0d writes, %0d reads, %0d scrolls (%0d clears), %0d idle opcodes",
               n_write, n_read, n_shift, n_clear, n_none);
      $display("responses checked: %0d, %0d out of range, windows from empty to saturated",
               sb.checked, sb.oor_count);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(40_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
